// File: hdl/mwps_pkg.sv
// Package for the masked word pattern scan: payload types, register indexes and constants.
package mwps_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_WORDS_DEFAULT  = 6;
  localparam int INDEX_BITS_DEFAULT = 32;

  // Pattern registers held in the block
  localparam int NUM_PATTERNS = 6;

  // Bytes per word is four: a shift by two
  localparam int BYTE_SHIFT = 2;

  // Configuration port widths
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_WORD_COUNT = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SCAN_LIMIT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_0  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_1  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_2  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_3  = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_4  = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_5  = 3'd7;

  // Result status codes
  localparam logic [1:0] STATUS_UNIQUE    = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_AMBIGUOUS = 2'd2;

  // Hit counter saturation values
  localparam logic [1:0] HITS_NONE = 2'd0;
  localparam logic [1:0] HITS_ONE  = 2'd1;
  localparam logic [1:0] HITS_TWO  = 2'd2;

  typedef struct packed {
    logic [31:0] data_word;
    logic        region_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] hit_index;
    logic [1:0]  hit_count;
  } out_item_t;

endpackage

// File: hdl/masked_word_pattern_scan.sv
// Masked multi-word pattern scan over a streamed region of 32-bit words.
//
//  channel   direction  handshake             payload
//  in        sink       in_valid / in_ready   in_data   (data_word, region_end)
//  out       source     out_valid / out_ready out_data  (status, hit_index, hit_count)
//  cfg       sink       cfg_write             cfg_index, cfg_data
//
// One beat is taken every cycle unless the input stage stalls: an input register
// feeds the window compares, which update the scan state and the result register
// as the beat leaves it; a result is offered once the region_end beat has left it.
// The input stage stalls only while a result waits and out_ready is low.
// Synchronous reset clears the scan state and loads the register defaults.
module masked_word_pattern_scan
  import mwps_pkg::*;
#(
  parameter int MAX_WORDS  = MAX_WORDS_DEFAULT,
  parameter int INDEX_BITS = INDEX_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_item_t               in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_item_t              out_data,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int WIN_DEPTH = (MAX_WORDS > 1) ? MAX_WORDS - 1 : 1;
  localparam int CMP_W     = (INDEX_BITS + 3 > 32) ? INDEX_BITS + 3 : 32;

  // Configuration registers
  logic [2:0]  word_count;
  logic [31:0] scan_limit;
  logic [31:0] pat_mask  [NUM_PATTERNS];
  logic [31:0] pat_value [NUM_PATTERNS];

  // Input stage
  logic     s1_valid;
  in_item_t s1_item;
  logic     s1_adv;
  logic     s1_fire;

  // Scan state
  logic [31:0]           window      [WIN_DEPTH];
  logic [INDEX_BITS-1:0] word_index;
  logic [1:0]            hits;
  logic [INDEX_BITS-1:0] first_hit;
  logic [1:0]            hits_next;
  logic [INDEX_BITS-1:0] first_hit_next;

  // Result register
  logic      res_valid;
  out_item_t res_item;

  // Compare datapath
  logic [2:0]       n_eff;
  logic [2:0]       n_m1;
  logic [CMP_W-1:0] end_bytes;
  logic             in_limit;
  logic             pos_ok;
  logic             pat_hit;
  logic [2:0]       back;
  logic [31:0]      sel_word;

  // Handshakes: advance the input stage unless a result waits with out_ready low
  assign s1_adv    = !res_valid || out_ready;
  assign s1_fire   = s1_valid && s1_adv;
  assign in_ready  = !s1_valid || s1_adv;
  assign out_valid = res_valid;
  assign out_data  = res_item;

  // Clamp the word count to the pattern registers and window length
  always_comb begin
    n_eff = word_count;
    if ({1'b0, n_eff} > 4'(MAX_WORDS)) begin
      n_eff = 3'(MAX_WORDS);
    end
    if (n_eff > 3'(NUM_PATTERNS)) begin
      n_eff = 3'(NUM_PATTERNS);
    end
    n_m1 = n_eff - 3'd1;
  end

  // Position test: enough words seen and the position ends inside the byte cap
  always_comb begin
    end_bytes = (CMP_W'(word_index) + CMP_W'(1)) << BYTE_SHIFT;
    in_limit  = (scan_limit == 32'd0) || (end_bytes <= CMP_W'(scan_limit));
    pos_ok    = (n_eff != 3'd0) && (word_index >= INDEX_BITS'(n_m1)) && in_limit;
  end

  // Masked compares of every pattern word against its window tap, in parallel
  always_comb begin
    pat_hit  = 1'b1;
    back     = 3'd0;
    sel_word = 32'd0;
    for (int k = 0; k < NUM_PATTERNS; k++) begin
      back     = n_m1 - 3'(k);
      sel_word = s1_item.data_word;
      for (int j = 0; j < WIN_DEPTH; j++) begin
        if (back == 3'(j + 1)) begin
          sel_word = window[j];
        end
      end
      if ((3'(k) < n_eff) && ((sel_word & pat_mask[k]) != pat_value[k])) begin
        pat_hit = 1'b0;
      end
    end
  end

  // Count hits, saturating at two, and keep the first position
  always_comb begin
    hits_next      = hits;
    first_hit_next = first_hit;
    if (pos_ok && pat_hit && (hits != HITS_TWO)) begin
      hits_next = hits + 2'd1;
      if (hits == HITS_NONE) begin
        first_hit_next = word_index - INDEX_BITS'(n_m1);
      end
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      word_count <= 3'd1;
      scan_limit <= 32'd0;
      for (int k = 0; k < NUM_PATTERNS; k++) begin
        pat_mask[k]  <= 32'd0;
        pat_value[k] <= 32'd0;
      end
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_WORD_COUNT: word_count <= cfg_data[2:0];
        REG_SCAN_LIMIT: scan_limit <= cfg_data[31:0];
        REG_PATTERN_0: begin
          pat_mask[0]  <= cfg_data[63:32];
          pat_value[0] <= cfg_data[31:0];
        end
        REG_PATTERN_1: begin
          pat_mask[1]  <= cfg_data[63:32];
          pat_value[1] <= cfg_data[31:0];
        end
        REG_PATTERN_2: begin
          pat_mask[2]  <= cfg_data[63:32];
          pat_value[2] <= cfg_data[31:0];
        end
        REG_PATTERN_3: begin
          pat_mask[3]  <= cfg_data[63:32];
          pat_value[3] <= cfg_data[31:0];
        end
        REG_PATTERN_4: begin
          pat_mask[4]  <= cfg_data[63:32];
          pat_value[4] <= cfg_data[31:0];
        end
        REG_PATTERN_5: begin
          pat_mask[5]  <= cfg_data[63:32];
          pat_value[5] <= cfg_data[31:0];
        end
        default: ;
      endcase
    end
  end

  // Input register: take a beat whenever the stage is free or moving on
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_data;
    end
  end

  // Scan state: shift the window, or clear everything at the region end
  always_ff @(posedge clk) begin
    if (rst) begin
      word_index <= '0;
      hits       <= HITS_NONE;
      first_hit  <= '0;
      for (int j = 0; j < WIN_DEPTH; j++) begin
        window[j] <= 32'd0;
      end
    end else if (s1_fire) begin
      if (s1_item.region_end) begin
        word_index <= '0;
        hits       <= HITS_NONE;
        first_hit  <= '0;
        for (int j = 0; j < WIN_DEPTH; j++) begin
          window[j] <= 32'd0;
        end
      end else begin
        word_index <= word_index + INDEX_BITS'(1);
        hits       <= hits_next;
        first_hit  <= first_hit_next;
        window[0]  <= s1_item.data_word;
        for (int j = 1; j < WIN_DEPTH; j++) begin
          window[j] <= window[j-1];
        end
      end
    end
  end

  // Result register: load at the region end, drop once the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_fire && s1_item.region_end) begin
      res_valid <= 1'b1;
    end else if (out_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_item.region_end) begin
      res_item.hit_count <= hits_next;
      unique case (hits_next)
        HITS_NONE: begin
          res_item.status    <= STATUS_NOT_FOUND;
          res_item.hit_index <= 32'd0;
        end
        HITS_ONE: begin
          res_item.status    <= STATUS_UNIQUE;
          res_item.hit_index <= 32'(first_hit_next);
        end
        default: begin
          res_item.status    <= STATUS_AMBIGUOUS;
          res_item.hit_index <= 32'(first_hit_next);
        end
      endcase
    end
  end

endmodule

// File: dv/scan_result_checker.sv
// Checker for the masked word pattern scan: tracks the registers, predicts results, compares.
module scan_result_checker
  import mwps_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  in_item_t               in_data,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  out_item_t              out_data,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     errors,
  output int                     pending
);

  // Register copies
  logic [2:0]  word_count;
  logic [31:0] scan_limit;
  logic [63:0] pattern [NUM_PATTERNS];

  // Scan state copies
  logic [31:0] history [MAX_WORDS_DEFAULT];
  logic [31:0] word_index;
  logic [1:0]  hits;
  logic [31:0] first_hit;

  out_item_t expected_results [$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  task automatic report_mismatch(input string what);
    $display("%0t: scan check: %s", $time, what);
    errors++;
  endtask

  function automatic int pattern_words_in_use();
    return (word_count > NUM_PATTERNS) ? NUM_PATTERNS : int'(word_count);
  endfunction

  // Test the position that ends with the word now arriving
  function automatic bit position_hits(input logic [31:0] newest, input int n);
    logic [31:0] word;
    int          back;
    for (int k = 0; k < n; k++) begin
      back = n - 1 - k;
      word = (back == 0) ? newest : history[back-1];
      if ((word & pattern[k][63:32]) != pattern[k][31:0]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic clear_scan();
    for (int k = 0; k < MAX_WORDS_DEFAULT; k++) history[k] = '0;
    word_index = '0;
    hits       = HITS_NONE;
    first_hit  = '0;
  endtask

  // Advance the scan by one word and queue a result at the region end
  task automatic predict_scan_word(input in_item_t beat);
    int        n;
    bit        in_limit;
    out_item_t res;
    n = pattern_words_in_use();
    if (n != 0 && word_index >= 32'(n - 1)) begin
      in_limit = (scan_limit == 0) ||
                 (({32'd0, word_index} + 64'd1) * 64'd4 <= {32'd0, scan_limit});
      if (in_limit && hits != HITS_TWO && position_hits(beat.data_word, n)) begin
        if (hits == HITS_NONE) first_hit = word_index - 32'(n - 1);
        hits = hits + 2'd1;
      end
    end
    if (beat.region_end) begin
      res.status    = (hits == HITS_ONE)  ? STATUS_UNIQUE :
                      (hits == HITS_NONE) ? STATUS_NOT_FOUND : STATUS_AMBIGUOUS;
      res.hit_index = (hits != HITS_NONE) ? first_hit : 32'd0;
      res.hit_count = hits;
      expected_results.push_back(res);
      clear_scan();
    end else begin
      for (int k = MAX_WORDS_DEFAULT - 1; k > 0; k--) history[k] = history[k-1];
      history[0] = beat.data_word;
      word_index = word_index + 32'd1;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      word_count = 3'd1;
      scan_limit = '0;
      for (int k = 0; k < NUM_PATTERNS; k++) pattern[k] = '0;
      clear_scan();
      expected_results.delete();
    end else begin
      // Predict from each accepted input beat
      if (in_valid && in_ready) predict_scan_word(in_data);

      // Compare each accepted result beat with the oldest expectation
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          want = expected_results.pop_front();
          if (out_data.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      out_data.status, want.status));
          if (out_data.hit_index !== want.hit_index)
            report_mismatch($sformatf("hit_index %0d, expected %0d",
                                      out_data.hit_index, want.hit_index));
          if (out_data.hit_count !== want.hit_count)
            report_mismatch($sformatf("hit_count %0d, expected %0d",
                                      out_data.hit_count, want.hit_count));
        end
      end

      // Register writes take effect from the next beat
      if (cfg_write) begin
        case (cfg_index)
          REG_WORD_COUNT: word_count = cfg_data[2:0];
          REG_SCAN_LIMIT: scan_limit = cfg_data[31:0];
          default:        pattern[cfg_index - REG_PATTERN_0] = cfg_data;
        endcase
      end
    end
    pending = expected_results.size();
  end

endmodule

// File: dv/masked_word_pattern_scan_test.sv
// Testbench top for the masked word pattern scan: clock, reset, stimulus and verdict.
module masked_word_pattern_scan_test;
  import mwps_pkg::*;

  localparam int PHASES       = 8;
  localparam int PHASE_WORDS  = 220;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 4;

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  in_item_t               in_data;
  logic                   out_valid;
  logic                   out_ready;
  out_item_t              out_data;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int                     errors;
  int                     pending;

  // Idle rates and the long receiver hold-off request
  int tx_idle_pct;
  int rx_stall_pct;
  bit hold_request;

  // Copies of the pattern registers for planting matches
  logic [2:0]  cur_count;
  logic [31:0] pat_mask  [NUM_PATTERNS];
  logic [31:0] pat_value [NUM_PATTERNS];
  int          words_sent;

  masked_word_pattern_scan dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  scan_result_checker checker_i (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Drop the whole run after a generous bound
  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off counted here
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Offer one beat, idling first at the current rate; return at the next falling edge
  task automatic send_word(input logic [31:0] word, input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data  <= '{data_word: word, region_end: last};
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  // Hold the input until every expected result has come and the pipe is empty
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    case (idx)
      REG_WORD_COUNT: cur_count = value[2:0];
      REG_SCAN_LIMIT: ;
      default: begin
        pat_mask[idx - REG_PATTERN_0]  = value[63:32];
        pat_value[idx - REG_PATTERN_0] = value[31:0];
      end
    endcase
  endtask

  // Build a region of random words with some pattern copies planted in it
  task automatic send_region(input int len, input int plants);
    logic [31:0] words [$];
    int          n;
    int          p;
    n = (cur_count > NUM_PATTERNS) ? NUM_PATTERNS : int'(cur_count);
    for (int i = 0; i < len; i++) words.push_back($urandom);
    if (n != 0 && len >= n) begin
      for (int j = 0; j < plants; j++) begin
        p = $urandom_range(len - n);
        for (int k = 0; k < n; k++)
          words[p+k] = ($urandom & ~pat_mask[k]) | pat_value[k];
      end
    end
    for (int i = 0; i < len; i++) send_word(words[i], i == len - 1);
  endtask

  // Pick a pattern word: clear, full, sparse or random mask; value mostly in the mask
  function automatic logic [63:0] random_pattern();
    logic [31:0] mask;
    logic [31:0] value;
    case ($urandom_range(7))
      0:       mask = 32'h0;
      1:       mask = 32'hFFFF_FFFF;
      2:       mask = $urandom & $urandom & $urandom;
      default: mask = $urandom;
    endcase
    value = ($urandom_range(7) == 0) ? $urandom : ($urandom & mask);
    return {mask, value};
  endfunction

  initial begin
    int          len;
    int          plants;
    int          r;
    int          phase_start;
    logic [31:0] limit;
    logic [2:0]  count;

    rst          = 1'b1;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_write    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_request = 1'b0;
    words_sent   = 0;
    cur_count    = 3'd1;
    for (int k = 0; k < NUM_PATTERNS; k++) begin
      pat_mask[k]  = '0;
      pat_value[k] = '0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Defaults: one all-zero pattern word hits every position
    send_word(32'h0, 1'b1);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'h0, 1'b1);

    // Zero word count never hits
    wait_drained();
    write_reg(REG_WORD_COUNT, 64'd0);
    cfg_write <= 1'b0;
    send_word(32'hA5A5_A5A5, 1'b0);
    send_word(32'h5A5A_5A5A, 1'b1);

    // Word count above the pattern store folds down to six
    wait_drained();
    write_reg(REG_WORD_COUNT, 64'd7);
    cfg_write <= 1'b0;
    for (int i = 0; i < 6; i++) send_word(32'hFFFF_FFFF, i == 5);

    // Region shorter than the pattern
    wait_drained();
    write_reg(REG_WORD_COUNT, 64'd2);
    cfg_write <= 1'b0;
    send_word(32'h1234_5678, 1'b1);

    // Byte cap of one word, then the widest cap
    wait_drained();
    write_reg(REG_WORD_COUNT, 64'd1);
    write_reg(REG_SCAN_LIMIT, 64'd4);
    cfg_write <= 1'b0;
    for (int i = 0; i < 3; i++) send_word($urandom, i == 2);
    wait_drained();
    write_reg(REG_SCAN_LIMIT, 64'hFFFF_FFFF_FFFF_FFFF);
    cfg_write <= 1'b0;
    send_word(32'h0, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b1);

    // Exact word: counting saturates at the second hit and keeps the first index
    wait_drained();
    write_reg(REG_SCAN_LIMIT, 64'd0);
    write_reg(REG_PATTERN_0, {32'hFFFF_FFFF, 32'h1234_5678});
    cfg_write <= 1'b0;
    send_word(32'h0, 1'b0);
    send_word(32'h1234_5678, 1'b0);
    send_word(32'h1234_5678, 1'b0);
    send_word(32'h1234_5678, 1'b1);

    // Random phases over register settings and idle rates
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      case (ph)
        0:       count = 3'd1;
        1:       count = 3'd6;
        2:       count = 3'd7;
        default: count = 3'($urandom_range(1, NUM_PATTERNS));
      endcase
      case (ph)
        0, 2, 4: limit = 32'd0;
        1:       limit = 32'hFFFF_FFFF;
        5:       limit = $urandom_range(1, 60);
        6:       limit = $urandom;
        default: limit = $urandom_range(1, 160);
      endcase
      write_reg(REG_WORD_COUNT, {$urandom, $urandom} & ~64'h7 | 64'(count));
      write_reg(REG_SCAN_LIMIT, {$urandom, limit});
      for (int k = 0; k < NUM_PATTERNS; k++)
        write_reg(REG_PATTERN_0 + CFG_INDEX_W'(k), random_pattern());
      cfg_write <= 1'b0;

      case (ph % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 83; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 83; end
        default: begin tx_idle_pct = 25; rx_stall_pct = 25; end
      endcase

      phase_start = words_sent;

      // Fill the block behind a long receiver hold-off
      if (ph == 4) begin
        hold_request = 1'b1;
        for (int i = 0; i < 24; i++) send_word($urandom, 1'b1);
      end

      while (words_sent - phase_start < PHASE_WORDS) begin
        // Pause the sender until the result queue empties, for regions started mid-phase
        if (ph == 5 && words_sent - phase_start >= PHASE_WORDS / 2 &&
            words_sent - phase_start < PHASE_WORDS / 2 + 12)
          wait_drained();
        len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        r   = $urandom_range(9);
        plants = (r < 2) ? 0 : (r < 7) ? 1 : 2;
        send_region(len, plants);
      end
    end

    // Drain and give the verdict
    wait_drained();
    repeat (10) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
